>>> rtl/box_overlap_pair_force_defines.svh
// Assertion macros for the box-overlap pair force engine.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BOX_OVERLAP_PAIR_FORCE_DEFINES_SVH
`define BOX_OVERLAP_PAIR_FORCE_DEFINES_SVH

// Same-cycle implication
`define BOPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BOPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bopf_pkg.sv
// Shared types, constants and helper functions of the box-overlap pair force engine.
// No dependencies.
package bopf_pkg;

  localparam int AXES   = 3;
  localparam int POS_W  = 24;
  localparam int HALF_W = 16;
  localparam int TYPE_W = 2;
  localparam int K_W    = 16;
  localparam int F_W    = 48;
  localparam int IDX_W  = 10;
  localparam int LC_W   = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int FRAC   = 8;

  // derived datapath widths
  localparam int D_W   = POS_W + 1;                  // axis distance
  localparam int W_W   = HALF_W + 1;                 // overlap width
  localparam int P1_W  = 2 * W_W - FRAC;             // (wx*wy)>>8
  localparam int P2_W  = P1_W + W_W - FRAC;          // (..*wz)>>8
  localparam int V_W   = P2_W + K_W - FRAC;          // (..*k)>>8
  localparam int V_LO  = V_W / 2 + 1;                // low slice of v
  localparam int V_HI  = V_W - V_LO;
  localparam int PL_W  = D_W + V_LO;
  localparam int PH_W  = D_W + V_HI;
  localparam int FULL_W = D_W + V_W;
  localparam int M_W   = FULL_W - FRAC;

  localparam logic [F_W-1:0] SAT_MAX = {1'b0, {(F_W-1){1'b1}}};
  localparam logic [F_W-1:0] SAT_MIN = {1'b1, {(F_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PAIR = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  localparam logic [CFG_ADDR_W-1:0] REG_K11    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_K12    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_K13    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_K22    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_K23    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_K33    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_NEWTON = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_LOCAL  = 3'd7;

  typedef logic [5:0][K_W-1:0] kreg_t;

  typedef struct packed {
    logic [AXES-1:0][POS_W-1:0]  pos;
    logic [AXES-1:0][HALF_W-1:0] half;
    logic [TYPE_W-1:0]           typ;
  } atom_row_t;

  typedef logic [AXES-1:0][F_W-1:0] force_vec_t;

  typedef struct packed {
    logic done;
    logic touch;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_I,
    ST_RD_J,
    ST_START,
    ST_WAIT,
    ST_ACC_RI,
    ST_ACC_WI,
    ST_ACC_RJ,
    ST_ACC_WJ,
    ST_DONE
  } state_t;

  function automatic logic [F_W-1:0] sat_add(input logic [F_W-1:0] a,
                                             input logic [F_W-1:0] b);
    logic [F_W:0] s;
    s = {a[F_W-1], a} + {b[F_W-1], b};
    if (s[F_W] != s[F_W-1]) begin
      return s[F_W] ? SAT_MIN : SAT_MAX;
    end
    return s[F_W-1:0];
  endfunction

  // Symmetric type-pair stiffness; unknown types give zero
  function automatic logic [K_W-1:0] stiffness(input logic [TYPE_W-1:0] ta,
                                               input logic [TYPE_W-1:0] tb,
                                               input int ntypes,
                                               input kreg_t k);
    logic [TYPE_W-1:0] lo;
    logic [TYPE_W-1:0] hi;
    logic [2:0]        sel;
    lo = (ta < tb) ? ta : tb;
    hi = (ta < tb) ? tb : ta;
    if (32'(hi) >= 32'(ntypes) || hi > 2'd2) begin
      return '0;
    end
    case (lo)
      2'd0:    sel = 3'(hi);
      2'd1:    sel = 3'(hi) + 3'd2;
      default: sel = 3'd5;
    endcase
    return k[sel];
  endfunction

endpackage

>>> rtl/bopf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bopf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bopf_dp.sv
// Pair geometry and force magnitude pipeline: overlap test, volume, stiffness, force.
// Depends on bopf_pkg.
module bopf_dp import bopf_pkg::*; #(
  parameter int NTYPES = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  atom_row_t  row_i,
  input  atom_row_t  row_j,
  input  kreg_t      kreg,
  output dp_stat_t   stat,
  output force_vec_t force_out
);

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld_r;

  logic signed [D_W-1:0] d_c   [AXES];
  logic [D_W-1:0]        ad_c  [AXES];
  logic [W_W-1:0]        sum_c [AXES];
  logic [W_W-1:0]        w_c   [AXES];
  logic [W_W-1:0]        gap_c [AXES];
  logic [W_W-1:0]        two_i [AXES];
  logic [W_W-1:0]        two_j [AXES];
  logic [AXES-1:0]       hit_c;

  // geometry held from start until the item leaves the pipeline
  logic [D_W-1:0]  ad_r  [AXES];
  logic [W_W-1:0]  w_r   [AXES];
  logic [AXES-1:0] neg_r;
  logic            touch_r;
  logic [K_W-1:0]  k_r;

  logic [P1_W-1:0]  p1_r;
  logic [P2_W-1:0]  p2_r;
  logic [V_W-1:0]   v_r;
  logic [PL_W-1:0]  lo_r [AXES];
  logic [PH_W-1:0]  hi_r [AXES];
  force_vec_t       force_r;

  logic [2*W_W-1:0]     m1_c;
  logic [P1_W+W_W-1:0]  m2_c;
  logic [P2_W+K_W-1:0]  m3_c;
  logic [FULL_W-1:0]    full_c [AXES];
  logic [M_W-1:0]       mag_c  [AXES];
  logic [F_W-1:0]       m48_c  [AXES];
  force_vec_t           force_c;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      d_c[a]   = D_W'($signed(row_i.pos[a])) - D_W'($signed(row_j.pos[a]));
      ad_c[a]  = d_c[a][D_W-1] ? D_W'(-d_c[a]) : D_W'(d_c[a]);
      sum_c[a] = W_W'(row_i.half[a]) + W_W'(row_j.half[a]);
      hit_c[a] = ad_c[a] < D_W'(sum_c[a]);
      gap_c[a] = W_W'(D_W'(sum_c[a]) - ad_c[a]);
      two_i[a] = {row_i.half[a], 1'b0};
      two_j[a] = {row_j.half[a], 1'b0};
      w_c[a]   = gap_c[a];
      if (two_i[a] < w_c[a]) begin
        w_c[a] = two_i[a];
      end
      if (two_j[a] < w_c[a]) begin
        w_c[a] = two_j[a];
      end
      if (!hit_c[a]) begin
        w_c[a] = '0;
      end
    end
  end

  always_comb begin
    m1_c = (2*W_W)'(w_r[0]) * (2*W_W)'(w_r[1]);
    m2_c = (P1_W+W_W)'(p1_r) * (P1_W+W_W)'(w_r[2]);
    m3_c = (P2_W+K_W)'(p2_r) * (P2_W+K_W)'(k_r);
    for (int a = 0; a < AXES; a++) begin
      full_c[a] = FULL_W'({hi_r[a], {V_LO{1'b0}}}) + FULL_W'(lo_r[a]);
      mag_c[a]  = full_c[a][FULL_W-1:FRAC];
      // clamp the magnitude to the largest positive 48-bit value
      m48_c[a]  = (|mag_c[a][M_W-1:F_W-1]) ? SAT_MAX : F_W'(mag_c[a][F_W-2:0]);
      force_c[a] = !touch_r ? '0 : (neg_r[a] ? F_W'(-m48_c[a]) : m48_c[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int a = 0; a < AXES; a++) begin
        ad_r[a]  <= ad_c[a];
        w_r[a]   <= w_c[a];
        neg_r[a] <= d_c[a][D_W-1];
      end
      touch_r <= &hit_c;
      k_r     <= stiffness(row_i.typ, row_j.typ, NTYPES, kreg);
    end
    if (vld_r[0]) begin
      p1_r <= m1_c[2*W_W-1:FRAC];
    end
    if (vld_r[1]) begin
      p2_r <= m2_c[P1_W+W_W-1:FRAC];
    end
    if (vld_r[2]) begin
      v_r <= m3_c[P2_W+K_W-1:FRAC];
    end
    if (vld_r[3]) begin
      for (int a = 0; a < AXES; a++) begin
        lo_r[a] <= PL_W'(ad_r[a]) * PL_W'(v_r[V_LO-1:0]);
        hi_r[a] <= PH_W'(ad_r[a]) * PH_W'(v_r[V_W-1:V_LO]);
      end
    end
    if (vld_r[4]) begin
      force_r <= force_c;
    end
  end

  assign stat.done  = vld_r[STAGES-1];
  assign stat.touch = touch_r;
  assign force_out  = force_r;

endmodule

>>> rtl/box_overlap_pair_force.sv
// Top level of the box-overlap pair force engine: sequencer, atom and accumulator RAMs.
// Depends on bopf_pkg, bopf_ram, bopf_dp and box_overlap_pair_force_defines.svh.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | opcode, atoms i/j, position, half-axes, type
//  out_    | output    | out_valid/out_ready | force x/y/z, contact
//  cfg_    | input     | cfg_we              | cfg_addr, cfg_wdata
//
// One transaction is in work at a time. A load writes the atom RAM; a read returns and clears
// the accumulator row of atom i; a pair takes two atom RAM reads, six pipeline stages, then,
// with contact, a read-modify-write of the row of atom i and, with reaction, of atom j.
// After reset the accumulator RAM is cleared one row a cycle, with in_ready low until all rows are clear.
// A finished result waits in the output register; the next transaction is taken meanwhile,
// and its own result stalls until the previous one has gone.
`include "box_overlap_pair_force_defines.svh"

module box_overlap_pair_force import bopf_pkg::*; #(
  parameter int ATOMS  = 1024,
  parameter int NTYPES = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic [IDX_W-1:0]         in_atom_i,
  input  logic [IDX_W-1:0]         in_atom_j,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic signed [POS_W-1:0]  in_pos_z,
  input  logic [HALF_W-1:0]        in_half_x,
  input  logic [HALF_W-1:0]        in_half_y,
  input  logic [HALF_W-1:0]        in_half_z,
  input  logic [TYPE_W-1:0]        in_type_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [F_W-1:0]    out_force_x,
  output logic signed [F_W-1:0]    out_force_y,
  output logic signed [F_W-1:0]    out_force_z,
  output logic                     out_contact,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [K_W-1:0]           cfg_wdata
);

  localparam int AW = $clog2(ATOMS);
  localparam int ACC_W = AXES * F_W;

  state_t state_r, state_nxt;

  kreg_t            kreg_r;
  logic             newton_r;
  logic [LC_W-1:0]  local_r;

  opcode_t          op_r;
  logic [IDX_W-1:0] ai_r, aj_r;
  atom_row_t        row_i_r;
  force_vec_t       f_r;
  force_vec_t       res_f_r;
  logic             res_c_r;
  logic [AW-1:0]    clr_r;

  logic             out_valid_r;
  force_vec_t       out_f_r;
  logic             out_c_r;

  logic             accept, i_ok, j_ok, reaction, out_free;
  opcode_t          in_op;

  logic             atom_we;
  logic [AW-1:0]    atom_waddr, atom_raddr;
  atom_row_t        atom_wdata;
  logic [$bits(atom_row_t)-1:0] atom_rdata;

  logic             acc_we;
  logic [AW-1:0]    acc_waddr, acc_raddr;
  logic [ACC_W-1:0] acc_wdata, acc_rdata;
  force_vec_t       acc_old;

  logic             dp_start;
  dp_stat_t         dp_stat;
  force_vec_t       dp_force;

  assign in_op    = opcode_t'(in_opcode);
  assign accept   = in_valid && in_ready;
  assign i_ok     = 32'(in_atom_i) < 32'(ATOMS);
  assign j_ok     = 32'(in_atom_j) < 32'(ATOMS);
  assign reaction = newton_r || (LC_W'(aj_r) < local_r);
  assign out_free = !out_valid_r || out_ready;
  assign acc_old  = force_vec_t'(acc_rdata);

  bopf_ram #(.WIDTH($bits(atom_row_t)), .DEPTH(ATOMS)) u_atom_ram (
    .clk   (clk),
    .we    (atom_we),
    .waddr (atom_waddr),
    .wdata (atom_wdata),
    .raddr (atom_raddr),
    .rdata (atom_rdata)
  );

  bopf_ram #(.WIDTH(ACC_W), .DEPTH(ATOMS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  bopf_dp #(.NTYPES(NTYPES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dp_start),
    .row_i     (row_i_r),
    .row_j     (atom_row_t'(atom_rdata)),
    .kreg      (kreg_r),
    .stat      (dp_stat),
    .force_out (dp_force)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(ATOMS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_PAIR: state_nxt = (i_ok && j_ok) ? ST_RD_I : ST_DONE;
            OP_READ: state_nxt = i_ok ? ST_ACC_RI : ST_DONE;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RD_I:   state_nxt = ST_RD_J;
      ST_RD_J:   state_nxt = ST_START;
      ST_START:  state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (dp_stat.done) begin
          state_nxt = dp_stat.touch ? ST_ACC_RI : ST_DONE;
        end
      end
      ST_ACC_RI: state_nxt = ST_ACC_WI;
      ST_ACC_WI: state_nxt = (op_r == OP_PAIR && reaction) ? ST_ACC_RJ : ST_DONE;
      ST_ACC_RJ: state_nxt = ST_ACC_WJ;
      ST_ACC_WJ: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory and pipeline controls
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    atom_we    = accept && (in_op == OP_LOAD) && i_ok;
    atom_waddr = AW'(in_atom_i);
    atom_wdata.pos  = {in_pos_z, in_pos_y, in_pos_x};
    atom_wdata.half = {in_half_z, in_half_y, in_half_x};
    atom_wdata.typ  = in_type_code;
    atom_raddr = (state_r == ST_RD_I) ? AW'(ai_r) : AW'(aj_r);
    acc_raddr  = (state_r == ST_ACC_RI) ? AW'(ai_r) : AW'(aj_r);
    dp_start   = (state_r == ST_START);
    acc_we     = 1'b0;
    acc_waddr  = AW'(aj_r);
    acc_wdata  = '0;
    case (state_r)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_r;
      end
      ST_ACC_WI: begin
        acc_we    = 1'b1;
        acc_waddr = AW'(ai_r);
        if (op_r == OP_PAIR) begin
          for (int a = 0; a < AXES; a++) begin
            acc_wdata[a*F_W +: F_W] = sat_add(acc_old[a], f_r[a]);
          end
        end
      end
      ST_ACC_WJ: begin
        acc_we = 1'b1;
        for (int a = 0; a < AXES; a++) begin
          acc_wdata[a*F_W +: F_W] = sat_add(acc_old[a], F_W'(-f_r[a]));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      kreg_r   <= '0;
      newton_r <= 1'b1;
      local_r  <= LC_W'(1024);
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_K11, REG_K12, REG_K13,
          REG_K22, REG_K23, REG_K33: kreg_r[cfg_addr] <= cfg_wdata;
          REG_NEWTON:                newton_r <= cfg_wdata[0];
          REG_LOCAL:                 local_r  <= cfg_wdata[LC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // transaction and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      ai_r    <= in_atom_i;
      aj_r    <= in_atom_j;
      res_f_r <= '0;
      res_c_r <= 1'b0;
    end
    if (state_r == ST_RD_J) begin
      row_i_r <= atom_row_t'(atom_rdata);
    end
    if (state_r == ST_WAIT && dp_stat.done) begin
      f_r     <= dp_force;
      res_f_r <= dp_force;
      res_c_r <= dp_stat.touch;
    end
    if (state_r == ST_ACC_WI && op_r == OP_READ) begin
      res_f_r <= acc_old;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_f_r <= res_f_r;
      out_c_r <= res_c_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_force_x = out_f_r[0];
  assign out_force_y = out_f_r[1];
  assign out_force_z = out_f_r[2];
  assign out_contact = out_c_r;

  `BOPF_ASSERT_NEXT(a_one_in_flight, accept, !in_ready, "second transaction taken while busy")
  `BOPF_ASSERT_IMPL(a_dp_done_wait, dp_stat.done, state_r == ST_WAIT, "pipeline done outside wait")
  `BOPF_ASSERT_NEXT(a_result_held, state_r == ST_DONE && out_valid_r && !out_ready, state_r == ST_DONE, "pending result overwritten")

endmodule
